FILE: design/ocrg_pkg.sv
// Shared constants and types of the orthographic camera ray generator.
`timescale 1ns / 1ps
`default_nettype none
package ocrg_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int UNIT_ONE   = 16384;
  localparam int UNIT_SHIFT = 14;

  localparam logic [2:0] REG_POSITION  = 3'd0;
  localparam logic [2:0] REG_TARGET    = 3'd1;
  localparam logic [2:0] REG_UP        = 3'd2;
  localparam logic [2:0] REG_SCREEN_LR = 3'd3;
  localparam logic [2:0] REG_SCREEN_BT = 3'd4;
  localparam logic [2:0] REG_WIDTH     = 3'd5;
  localparam logic [2:0] REG_HEIGHT    = 3'd6;

  // Three Q2.14 components, x in the low slot.
  typedef logic [2:0][15:0] uvec_t;

  typedef struct packed {
    uvec_t u;
    uvec_t v;
    uvec_t w;
    logic  bad;
  } frame_t;

endpackage
`default_nettype wire

FILE: design/ocrg_frame.sv
// Sequential builder of the camera basis: backward (eye minus target), right and up unit vectors.
`timescale 1ns / 1ps
`default_nettype none
module ocrg_frame (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [47:0]    position,
  input  logic [47:0]    target,
  input  logic [47:0]    up,
  output ocrg_pkg::frame_t frame,
  output logic           busy
);
  import ocrg_pkg::*;

  typedef logic [2:0][33:0] wvec_t;
  typedef logic [2:0][32:0] mvec_t;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOADW = 4'd1;
  localparam logic [3:0] S_LOADU = 4'd2;
  localparam logic [3:0] S_LOADV = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_RINIT = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_STORE = 4'd11;

  localparam logic [32:0] NORM_HI = 33'd1 << 20;
  localparam logic [32:0] NORM_LO = 33'd1 << 19;
  localparam logic [5:0]  DIV_LAST = 6'd44;

  logic [3:0]  state;
  logic [1:0]  phase;
  logic [1:0]  idx;
  wvec_t       cvec;
  mvec_t       mag;
  logic [32:0] mmax;
  logic [41:0] ssum;
  logic [61:0] rs;
  logic [62:0] res;
  logic [62:0] rbit;
  logic [31:0] rem;
  logic [44:0] nq;
  logic [5:0]  cnt;
  uvec_t       bu, bv, bw;
  logic        bad;

  mvec_t       absc;
  logic [32:0] maxc;
  logic [19:0] sqin;
  logic [39:0] sq;
  logic [63:0] rsum;
  logic        rge;
  logic [32:0] dt;
  logic        dge;
  logic [15:0] qcap;
  logic [15:0] qval;
  logic [3:0]  after_phase;
  wvec_t       diff_et;

  function automatic wvec_t cross3(input uvec_t a, input uvec_t b);
    logic signed [31:0] p0, p1, p2, p3, p4, p5;
    wvec_t o;
    p0 = $signed(a[1]) * $signed(b[2]);
    p1 = $signed(a[2]) * $signed(b[1]);
    p2 = $signed(a[2]) * $signed(b[0]);
    p3 = $signed(a[0]) * $signed(b[2]);
    p4 = $signed(a[0]) * $signed(b[1]);
    p5 = $signed(a[1]) * $signed(b[0]);
    o[0] = 34'(p0) - 34'(p1);
    o[1] = 34'(p2) - 34'(p3);
    o[2] = 34'(p4) - 34'(p5);
    return o;
  endfunction

  always_comb begin
    maxc = '0;
    for (int i = 0; i < 3; i++) begin
      absc[i] = cvec[i][33] ? 33'(~cvec[i] + 34'd1) : cvec[i][32:0];
      if (absc[i] > maxc) begin
        maxc = absc[i];
      end
      diff_et[i] = 34'($signed(position[16*i +: 16])) - 34'($signed(target[16*i +: 16]));
    end
    sqin = mag[idx][19:0];
    sq   = sqin * sqin;
    rsum = {1'b0, res} + {1'b0, rbit};
    rge  = {2'b0, rs} >= rsum;
    dt   = {rem, nq[44]};
    dge  = dt >= {1'b0, res[31:0]};
    qcap = (nq > 45'(UNIT_ONE)) ? 16'(UNIT_ONE) : nq[15:0];
    qval = cvec[idx][33] ? 16'(16'd0 - qcap) : qcap;
    case (phase)
      2'd0:    after_phase = S_LOADU;
      2'd1:    after_phase = S_LOADV;
      default: after_phase = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOADW;
      bad   <= 1'b0;
    end else if (start) begin
      state <= S_LOADW;
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_LOADW: begin
          bad   <= 1'b0;
          phase <= 2'd0;
          cvec  <= diff_et;
          state <= S_ABS;
        end
        S_LOADU: begin
          phase <= 2'd1;
          cvec  <= cross3(uvec_t'(up), bw);
          state <= S_ABS;
        end
        S_LOADV: begin
          phase <= 2'd2;
          cvec  <= cross3(bw, bu);
          state <= S_ABS;
        end
        S_ABS: begin
          mag  <= absc;
          mmax <= maxc;
          if (maxc == '0) begin
            // A zero vector cannot be normalized: the frame is degenerate.
            bad <= 1'b1;
            case (phase)
              2'd0:    bw <= '0;
              2'd1:    bu <= '0;
              default: bv <= '0;
            endcase
            state <= after_phase;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (mmax >= NORM_HI) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
            mmax <= mmax >> 1;
          end else if (mmax < NORM_LO) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
            mmax <= mmax << 1;
          end else begin
            ssum  <= '0;
            idx   <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          ssum <= ssum + 42'(sq);
          if (idx == 2'd2) begin
            state <= S_RINIT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_RINIT: begin
          rs    <= {ssum, 20'b0};
          res   <= '0;
          rbit  <= {1'b1, 62'b0};
          idx   <= 2'd0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          // One result bit of the integer square root per cycle.
          if (rbit == '0) begin
            state <= S_DINIT;
          end else begin
            if (rge) begin
              rs  <= 62'({2'b0, rs} - rsum);
              res <= (res >> 1) + rbit;
            end else begin
              res <= res >> 1;
            end
            rbit <= rbit >> 2;
          end
        end
        S_DINIT: begin
          nq    <= 45'({mag[idx][19:0], 24'b0}) + 45'(res[31:1]);
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= dge ? 32'(dt - {1'b0, res[31:0]}) : dt[31:0];
          nq  <= {nq[43:0], dge};
          cnt <= cnt + 6'd1;
          if (cnt == DIV_LAST) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          case (phase)
            2'd0:    bw[idx] <= qval;
            2'd1:    bu[idx] <= qval;
            default: bv[idx] <= qval;
          endcase
          if (idx == 2'd2) begin
            state <= after_phase;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_DINIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign frame.u   = bu;
  assign frame.v   = bv;
  assign frame.w   = bw;
  assign frame.bad = bad;

endmodule
`default_nettype wire

FILE: design/ocrg_ray.sv
// Per-pixel pipeline: screen mapping with a pipelined divider, basis products, origin.
`timescale 1ns / 1ps
`default_nettype none
module ocrg_ray (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ocrg_pkg::PIXEL_BITS-1:0]     pixel_x,
  input  logic [ocrg_pkg::PIXEL_BITS-1:0]     pixel_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  origin_x,
  output logic signed [31:0]                  origin_y,
  output logic signed [31:0]                  origin_z,
  output logic signed [15:0]                  dir_x,
  output logic signed [15:0]                  dir_y,
  output logic signed [15:0]                  dir_z,
  output logic                                frame_bad,
  input  logic [47:0]                         position,
  input  logic [31:0]                         screen_lr,
  input  logic [31:0]                         screen_bt,
  input  logic [12:0]                         width,
  input  logic [12:0]                         height,
  input  ocrg_pkg::frame_t                    frame,
  input  logic                                busy
);
  import ocrg_pkg::*;

  // Span magnitude (16) times 2x+1, scaled by the fraction, plus one bit of headroom.
  localparam int NUM_W = 16 + (PIXEL_BITS + 1) + FRAC_BITS + 1;
  localparam int DEN_W = 14;
  localparam int ST_W  = DEN_W + NUM_W;
  localparam int US_W  = NUM_W + 2;
  localparam int PR_W  = US_W + 16;
  localparam int ACC_W = PR_W + 1;
  localparam int OUT_W = ACC_W - UNIT_SHIFT + 1;

  function automatic logic [NUM_W:0] numer(input logic [31:0] win,
                                           input logic [PIXEL_BITS-1:0] pix,
                                           input logic [12:0] half);
    logic signed [16:0]      span;
    logic [15:0]             smag;
    logic [PIXEL_BITS+16:0]  prod;
    logic [NUM_W-1:0]        num;
    span = 17'($signed(win[31:16])) - 17'($signed(win[15:0]));
    smag = span[16] ? 16'(-span) : span[15:0];
    prod = smag * {pix, 1'b1};
    num  = NUM_W'({prod, {FRAC_BITS{1'b0}}}) + NUM_W'(half);
    return {span[16], num};
  endfunction

  // One restoring step: the remainder sits above the shifting dividend and quotient.
  function automatic logic [ST_W-1:0] dstep(input logic [ST_W-1:0] st,
                                            input logic [DEN_W-1:0] den);
    logic [DEN_W-1:0] rm;
    logic [NUM_W-1:0] nqv;
    logic [DEN_W:0]   t;
    logic             ge;
    rm  = st[ST_W-1:NUM_W];
    nqv = st[NUM_W-1:0];
    t   = {rm, nqv[NUM_W-1]};
    ge  = t >= {1'b0, den};
    rm  = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
    return {rm, nqv[NUM_W-2:0], ge};
  endfunction

  logic [ST_W-1:0] dx [NUM_W+1];
  logic [ST_W-1:0] dy [NUM_W+1];
  logic            sx [NUM_W+1];
  logic            sy [NUM_W+1];
  logic            vld [NUM_W+1];

  logic signed [US_W-1:0]  us, vs;
  logic                    vu;
  logic signed [PR_W-1:0]  pu [3];
  logic signed [PR_W-1:0]  pv [3];
  logic                    vm;
  logic signed [ACC_W-1:0] acc [3];
  logic                    va;

  logic [12:0]       half_x, half_y;
  logic [DEN_W-1:0]  den_x, den_y;
  logic [NUM_W:0]    ent_x, ent_y;
  logic signed [US_W-1:0] us_n, vs_n, qxs, qys;
  logic signed [ACC_W-1:0] biased [3];
  logic signed [OUT_W-1:0] osum [3];
  logic [31:0]       osat [3];
  logic [OUT_W-32:0] ohi [3];
  logic              out_take, adv, accept;

  assign out_take = !out_valid || !out_stall;
  // The whole pipe may move when the result slot frees or the last stage is a bubble.
  assign adv      = out_take || !va;
  assign accept   = in_valid && !busy && adv;
  assign in_stall = busy || !adv;

  always_comb begin
    half_x = (width == '0) ? 13'd1 : width;
    half_y = (height == '0) ? 13'd1 : height;
    den_x  = {half_x, 1'b0};
    den_y  = {half_y, 1'b0};
    ent_x  = numer(screen_lr, pixel_x, half_x);
    ent_y  = numer(screen_bt, pixel_y, half_y);
    qxs    = $signed({2'b0, dx[NUM_W][NUM_W-1:0]});
    qys    = $signed({2'b0, dy[NUM_W][NUM_W-1:0]});
    us_n   = (US_W'($signed(screen_lr[15:0])) <<< FRAC_BITS) + (sx[NUM_W] ? -qxs : qxs);
    vs_n   = (US_W'($signed(screen_bt[15:0])) <<< FRAC_BITS) + (sy[NUM_W] ? -qys : qys);
    for (int i = 0; i < 3; i++) begin
      // Round half away from zero on the way down to the vector fraction.
      biased[i] = acc[i] + (acc[i][ACC_W-1] ? ACC_W'(UNIT_ONE / 2 - 1) : ACC_W'(UNIT_ONE / 2));
      osum[i]   = OUT_W'(biased[i] >>> UNIT_SHIFT) + OUT_W'($signed(position[16*i +: 16]));
      ohi[i]    = osum[i][OUT_W-1:31];
      if (ohi[i] == '0 || ohi[i] == '1) begin
        osat[i] = osum[i][31:0];
      end else begin
        osat[i] = osum[i][OUT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NUM_W; k++) vld[k] <= 1'b0;
      vu <= 1'b0;
      vm <= 1'b0;
      va <= 1'b0;
    end else if (adv) begin
      vld[0] <= accept;
      for (int k = 0; k < NUM_W; k++) vld[k+1] <= vld[k];
      vu <= vld[NUM_W];
      vm <= vu;
      va <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx[0] <= {{DEN_W{1'b0}}, ent_x[NUM_W-1:0]};
      dy[0] <= {{DEN_W{1'b0}}, ent_y[NUM_W-1:0]};
      sx[0] <= ent_x[NUM_W];
      sy[0] <= ent_y[NUM_W];
      for (int k = 0; k < NUM_W; k++) begin
        dx[k+1] <= dstep(dx[k], den_x);
        dy[k+1] <= dstep(dy[k], den_y);
        sx[k+1] <= sx[k];
        sy[k+1] <= sy[k];
      end
      us <= us_n;
      vs <= vs_n;
      for (int i = 0; i < 3; i++) begin
        pu[i]  <= $signed(frame.u[i]) * us;
        pv[i]  <= $signed(frame.v[i]) * vs;
        acc[i] <= ACC_W'(pu[i]) + ACC_W'(pv[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      frame_bad <= frame.bad;
      if (frame.bad) begin
        origin_x <= '0;
        origin_y <= '0;
        origin_z <= '0;
        dir_x    <= '0;
        dir_y    <= '0;
        dir_z    <= '0;
      end else begin
        origin_x <= osat[0];
        origin_y <= osat[1];
        origin_z <= osat[2];
        dir_x    <= 16'(-$signed(frame.w[0]));
        dir_y    <= 16'(-$signed(frame.w[1]));
        dir_z    <= 16'(-$signed(frame.w[2]));
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/ortho_camera_ray_generation.sv
// Top level of the orthographic camera ray generator: register file and both engines.
//
//   channel   direction  handshake               word
//   in        sink       in_valid / in_stall      pixel_x, pixel_y
//   out       source     out_valid / out_stall    origin_*, dir_*, frame_bad
//   cfg       sink       APB psel/penable/pready  seven camera and screen registers
//
// One pixel enters per cycle when not stalled or held off; its ray passes the 38-stage
// restoring divider that maps the pixel centre into the screen window.
// After reset and after every register write the basis is rebuilt by a shared
// square-root and divide sequencer; pixels are held off meanwhile.
// A stalled output freezes the pipe only once its last stage holds a word.
`timescale 1ns / 1ps
`default_nettype none
module ortho_camera_ray_generation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ocrg_pkg::PIXEL_BITS-1:0] pixel_x,
  input  logic [ocrg_pkg::PIXEL_BITS-1:0] pixel_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              origin_x,
  output logic signed [31:0]              origin_y,
  output logic signed [31:0]              origin_z,
  output logic signed [15:0]              dir_x,
  output logic signed [15:0]              dir_y,
  output logic signed [15:0]              dir_z,
  output logic                            frame_bad,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [5:0]                      paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);
  import ocrg_pkg::*;

  logic [47:0] cam_position, cam_target, cam_up;
  logic [31:0] screen_left_right, screen_bottom_top;
  logic [12:0] image_width, image_height;
  logic [2:0]  reg_sel;
  logic        wr;
  logic        rebuild;
  logic        busy;
  frame_t      frame;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign wr      = psel && penable && pwrite && pready;
  assign rebuild = wr && (reg_sel <= REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_position      <= 48'h0000_0000_0000;
      cam_target        <= 48'hFF00_0000_0000;
      cam_up            <= 48'h0000_0100_0000;
      screen_left_right <= 32'h0001_FFFF;
      screen_bottom_top <= 32'h0001_FFFF;
      image_width       <= 13'd640;
      image_height      <= 13'd480;
    end else if (wr) begin
      unique case (reg_sel)
        REG_POSITION:  cam_position      <= pwdata[47:0];
        REG_TARGET:    cam_target        <= pwdata[47:0];
        REG_UP:        cam_up            <= pwdata[47:0];
        REG_SCREEN_LR: screen_left_right <= pwdata[31:0];
        REG_SCREEN_BT: screen_bottom_top <= pwdata[31:0];
        REG_WIDTH:     image_width       <= pwdata[12:0];
        REG_HEIGHT:    image_height      <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POSITION:  prdata = {16'b0, cam_position};
      REG_TARGET:    prdata = {16'b0, cam_target};
      REG_UP:        prdata = {16'b0, cam_up};
      REG_SCREEN_LR: prdata = {32'b0, screen_left_right};
      REG_SCREEN_BT: prdata = {32'b0, screen_bottom_top};
      REG_WIDTH:     prdata = {51'b0, image_width};
      REG_HEIGHT:    prdata = {51'b0, image_height};
      default:       prdata = '0;
    endcase
  end

  ocrg_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .start    (rebuild),
    .position (cam_position),
    .target   (cam_target),
    .up       (cam_up),
    .frame    (frame),
    .busy     (busy)
  );

  ocrg_ray u_ray (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .origin_z  (origin_z),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .frame_bad (frame_bad),
    .position  (cam_position),
    .screen_lr (screen_left_right),
    .screen_bt (screen_bottom_top),
    .width     (image_width),
    .height    (image_height),
    .frame     (frame),
    .busy      (busy)
  );

endmodule
`default_nettype wire
